@@ rtl/stb_pkg.sv @@
// Shared constants and types of the scaled, color-keyed, translated blitter.
package stb_pkg;

    localparam int FB_WIDTH          = 256;
    localparam int FB_HEIGHT         = 192;
    localparam int TRANSPARENT_INDEX = 255;
    localparam int MAX_PIC_SIDE      = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 8;
    localparam int ADDR_W    = 16;
    localparam int TABLE_DEPTH = 256;

    localparam int SIDE_W    = $clog2(MAX_PIC_SIDE + 1);
    localparam int SCOL_W    = $clog2(MAX_PIC_SIDE);
    localparam int ORG_W     = CFG_W - 1;
    localparam int DROW_W    = $clog2(FB_HEIGHT + 1);
    localparam int DCOL_W    = $clog2(FB_WIDTH + 1);
    localparam int GEO_W     = CFG_W + 2;
    localparam int ACC_W     = 26;
    localparam int FRAC_W    = 16;

    localparam int STEP_X = (320 << 16) / 256;
    localparam int STEP_Y = (200 << 16) / 192;

    // w * 256 / 320 is w * 4 / 5; w * 192 / 200 is w * 24 / 25.
    localparam int SCALE_X_MUL   = 4 * 3277;
    localparam int SCALE_X_SHIFT = 14;
    localparam int SCALE_Y_MUL   = 24 * 41944;
    localparam int SCALE_Y_SHIFT = 20;
    localparam int SW_PROD_W     = SIDE_W + 15;
    localparam int SH_PROD_W     = SIDE_W + 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X     = 3'd0,
        REG_DEST_Y     = 3'd1,
        REG_PIC_WIDTH  = 3'd2,
        REG_PIC_HEIGHT = 3'd3,
        REG_BLIT_MODE  = 3'd4,
        REG_SCALE_ON   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        BLIT_OPAQUE = 2'd0,
        BLIT_KEYED  = 2'd1,
        BLIT_XLATE  = 2'd2
    } blit_mode_t;

    localparam logic ITEM_PIXEL = 1'b0;

endpackage

@@ rtl/stb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/scaled_transparent_translated_blit_unit.sv @@
// Top level of the scaled, color-keyed, translated blitter.
// A pixel item's framebuffer write is registered in s1, then in the output register.
// Throughput: one item per cycle; the translation RAM takes one write or one read a cycle.
// An input item is held off only while the output register holds a stalled write and the
// stage behind it is full. Reset is asynchronous: registers return to their defaults and
// the stream restarts at the top-left pixel; the translation RAM is not cleared.
module scaled_transparent_translated_blit_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [stb_pkg::PIX_W-1:0]         pixel_value,
    input  logic                              first_pixel,
    input  logic [stb_pkg::PIX_W-1:0]         table_index,
    input  logic [stb_pkg::PIX_W-1:0]         table_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stb_pkg::ADDR_W-1:0]        fb_address,
    output logic [stb_pkg::PIX_W-1:0]         pixel_out
);

    import stb_pkg::*;

    logic signed [CFG_W-1:0] dest_x_reg, dest_y_reg;
    logic [CFG_W-1:0]        pic_width_reg, pic_height_reg;
    logic [1:0]              blit_mode_reg;
    logic                    scale_on_reg;

    logic [SIDE_W-1:0] src_row_reg, src_row_next;
    logic [SCOL_W-1:0] src_col_reg, src_col_next;
    logic [DROW_W-1:0] dst_row_reg, dst_row_next;
    logic [DCOL_W-1:0] dst_col_reg, dst_col_next;
    logic [ACC_W-1:0]  row_accum_reg, row_accum_next;
    logic [ACC_W-1:0]  col_accum_reg, col_accum_next;
    logic              row_selected_reg, row_selected_next;

    logic              s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic              s1_xlate_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [PIX_W-1:0]  out_px_reg;
    logic [PIX_W-1:0]  table_q;

    logic              accept_in, pix_accept, table_write, s1_go;
    logic [SIDE_W-1:0] src_row_b;
    logic [SCOL_W-1:0] src_col_b;
    logic [DROW_W-1:0] dst_row_b;
    logic [DCOL_W-1:0] dst_col_b;
    logic [ACC_W-1:0]  row_accum_b, col_accum_b;
    logic              row_selected_b;

    logic [SIDE_W-1:0]    pw, ph, sw, sh;
    logic [SW_PROD_W-1:0] sw_prod;
    logic [SH_PROD_W-1:0] sh_prod;
    logic [ORG_W-1:0]     x0, y0;
    logic signed [GEO_W-1:0] w_raw, h_raw, w_clip, h_clip;
    logic signed [GEO_W-1:0] x0_s, y0_s, srow_s, scol_s, drow_s, dcol_s;
    logic              active, row_hit, col_hit, geo_emit, keyed_out, emit;
    logic [SIDE_W:0]   src_col_inc;
    logic [ADDR_W-1:0] dr, dc, row_base, addr_calc;

    assign accept_in   = in_valid && !in_stall;
    assign pix_accept  = accept_in && (mode == ITEM_PIXEL);
    assign table_write = accept_in && (mode != ITEM_PIXEL);
    assign s1_go       = !out_valid_reg || !out_stall;
    assign in_stall    = s1_valid_reg && !s1_go;

    always_comb
    begin
        if (first_pixel)
        begin
            src_row_b      = '0;
            src_col_b      = '0;
            dst_row_b      = '0;
            dst_col_b      = '0;
            row_accum_b    = '0;
            col_accum_b    = '0;
            row_selected_b = 1'b1;
        end
        else
        begin
            src_row_b      = src_row_reg;
            src_col_b      = src_col_reg;
            dst_row_b      = dst_row_reg;
            dst_col_b      = dst_col_reg;
            row_accum_b    = row_accum_reg;
            col_accum_b    = col_accum_reg;
            row_selected_b = row_selected_reg;
        end

        pw = (pic_width_reg > CFG_W'(MAX_PIC_SIDE)) ? SIDE_W'(MAX_PIC_SIDE)
                                                    : SIDE_W'(pic_width_reg);
        ph = (pic_height_reg > CFG_W'(MAX_PIC_SIDE)) ? SIDE_W'(MAX_PIC_SIDE)
                                                     : SIDE_W'(pic_height_reg);
        x0 = dest_x_reg[CFG_W-1] ? '0 : dest_x_reg[ORG_W-1:0];
        y0 = dest_y_reg[CFG_W-1] ? '0 : dest_y_reg[ORG_W-1:0];

        sw_prod = SW_PROD_W'(pw) * SW_PROD_W'(SCALE_X_MUL);
        sh_prod = SH_PROD_W'(ph) * SH_PROD_W'(SCALE_Y_MUL);
        sw      = SIDE_W'(sw_prod >> SCALE_X_SHIFT);
        sh      = SIDE_W'(sh_prod >> SCALE_Y_SHIFT);

        w_raw  = scale_on_reg ? GEO_W'(sw) : GEO_W'(pw);
        h_raw  = scale_on_reg ? GEO_W'(sh) : GEO_W'(ph);
        x0_s   = GEO_W'(x0);
        y0_s   = GEO_W'(y0);
        srow_s = GEO_W'(src_row_b);
        scol_s = GEO_W'(src_col_b);
        drow_s = GEO_W'(dst_row_b);
        dcol_s = GEO_W'(dst_col_b);
        w_clip = (x0_s + w_raw > GEO_W'(FB_WIDTH)) ? GEO_W'(FB_WIDTH) - x0_s : w_raw;
        h_clip = (y0_s + h_raw > GEO_W'(FB_HEIGHT)) ? GEO_W'(FB_HEIGHT) - y0_s : h_raw;

        active  = (pw != '0) && (ph != '0) && (src_row_b < ph);
        row_hit = (SIDE_W'(row_accum_b[ACC_W-1:FRAC_W]) == src_row_b) && (drow_s < h_clip);
        col_hit = (SCOL_W'(col_accum_b[ACC_W-1:FRAC_W]) == src_col_b) && (dcol_s < w_clip);
        geo_emit = scale_on_reg ? (row_hit && col_hit)
                                : ((srow_s < h_clip) && (scol_s < w_clip));
        keyed_out = (blit_mode_reg != BLIT_OPAQUE) && (pixel_value == PIX_W'(TRANSPARENT_INDEX));
        emit = pix_accept && active && geo_emit && !keyed_out;

        dr = scale_on_reg ? ADDR_W'(dst_row_b) : ADDR_W'(src_row_b);
        dc = scale_on_reg ? ADDR_W'(dst_col_b) : ADDR_W'(src_col_b);
        row_base  = ADDR_W'(y0) + dr;
        addr_calc = ADDR_W'(row_base * ADDR_W'(FB_WIDTH)) + ADDR_W'(x0) + dc;

        src_row_next      = src_row_b;
        src_col_next      = src_col_b;
        dst_row_next      = dst_row_b;
        dst_col_next      = dst_col_b;
        row_accum_next    = row_accum_b;
        col_accum_next    = col_accum_b;
        row_selected_next = row_selected_b;
        src_col_inc       = (SIDE_W + 1)'(src_col_b) + 1'b1;

        if (active)
        begin
            if (scale_on_reg)
            begin
                row_selected_next = row_hit;
                if (col_hit)
                begin
                    dst_col_next   = dst_col_b + 1'b1;
                    col_accum_next = col_accum_b + ACC_W'(STEP_X);
                end
            end
            if (src_col_inc >= (SIDE_W + 1)'(pw))
            begin
                if (scale_on_reg && row_hit)
                begin
                    dst_row_next   = dst_row_b + 1'b1;
                    row_accum_next = row_accum_b + ACC_W'(STEP_Y);
                end
                src_col_next   = '0;
                dst_col_next   = '0;
                col_accum_next = '0;
                src_row_next   = src_row_b + 1'b1;
            end
            else
            begin
                src_col_next = SCOL_W'(src_col_inc);
            end
        end

        if (accept_in)
        begin
            s1_valid_next = emit;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    stb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (table_write),
        .waddr (table_index),
        .wdata (table_value),
        .re    (pix_accept),
        .raddr (pixel_value),
        .rdata (table_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg       <= '0;
            dest_y_reg       <= '0;
            pic_width_reg    <= CFG_W'(1);
            pic_height_reg   <= CFG_W'(1);
            blit_mode_reg    <= BLIT_OPAQUE;
            scale_on_reg     <= 1'b0;
            src_row_reg      <= '0;
            src_col_reg      <= '0;
            dst_row_reg      <= '0;
            dst_col_reg      <= '0;
            row_accum_reg    <= '0;
            col_accum_reg    <= '0;
            row_selected_reg <= 1'b1;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEST_X:     dest_x_reg     <= cfg_data;
                    REG_DEST_Y:     dest_y_reg     <= cfg_data;
                    REG_PIC_WIDTH:  pic_width_reg  <= cfg_data;
                    REG_PIC_HEIGHT: pic_height_reg <= cfg_data;
                    REG_BLIT_MODE:  blit_mode_reg  <= cfg_data[1:0];
                    REG_SCALE_ON:   scale_on_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (pix_accept)
            begin
                src_row_reg      <= src_row_next;
                src_col_reg      <= src_col_next;
                dst_row_reg      <= dst_row_next;
                dst_col_reg      <= dst_col_next;
                row_accum_reg    <= row_accum_next;
                col_accum_reg    <= col_accum_next;
                row_selected_reg <= row_selected_next;
            end
            s1_valid_reg <= s1_valid_next;
            if (s1_go)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_addr_reg  <= addr_calc;
            s1_px_reg    <= pixel_value;
            s1_xlate_reg <= blit_mode_reg[1];
        end
        if (s1_go && s1_valid_reg)
        begin
            out_addr_reg <= s1_addr_reg;
            out_px_reg   <= s1_xlate_reg ? table_q : s1_px_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fb_address = out_addr_reg;
    assign pixel_out  = out_px_reg;

endmodule

@@ rtl/stb_checker.sv @@
// Port-level checker for the blitter top level and its bind statement.
module stb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [stb_pkg::ADDR_W-1:0] fb_address,
    input logic [stb_pkg::PIX_W-1:0]  pixel_out
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fb_address) && $stable(pixel_out))
        else $error("A stalled write changed or vanished.");

    a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("A write left the output without being taken.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input held off while the output was free.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!out_valid) && !in_take && $past(!in_take) |=> !out_valid)
        else $error("A write appeared with no item in flight.");

endmodule

bind scaled_transparent_translated_blit_unit stb_checker u_stb_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for the blitter: predicts every framebuffer write and compares it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    localparam logic ITEM_TABLE_LOAD   = ~ITEM_PIXEL;
    localparam int   BLIT_UNUSED       = 3;
    localparam int   FULL_W            = 320;
    localparam int   SCALED_W          = 256;
    localparam int   FULL_H            = 200;
    localparam int   SCALED_H          = 192;
    localparam int   DRAIN_CYCLES      = 8;
    localparam int   LONG_HOLD         = 60;
    localparam int   TOTAL_ITEMS       = 850;
    localparam int   BIG_PICTURE_ITEMS = 280;

    typedef struct packed {
        logic [ADDR_W-1:0] fb_address;
        logic [PIX_W-1:0]  pixel_out;
    } fb_write_t;

    class fb_write_checker;
        logic [CFG_W-1:0] dest_x, dest_y, pic_width, pic_height;
        logic [1:0]       blit_mode;
        logic             scale_on;
        logic [PIX_W-1:0] xlate [TABLE_DEPTH];
        int               in_row, in_col, out_row, out_col, row_phase, col_phase;
        bit               row_taken;
        fb_write_t        pending_writes[$];
        int               errors;
        int               writes_checked;

        function new();
            dest_x = '0;
            dest_y = '0;
            pic_width = CFG_W'(1);
            pic_height = CFG_W'(1);
            blit_mode = BLIT_OPAQUE;
            scale_on = 1'b0;
            foreach (xlate[i]) xlate[i] = '0;
            errors = 0;
            writes_checked = 0;
            rewind_stream();
        endfunction

        function void rewind_stream();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
            row_phase = 0;
            col_phase = 0;
            row_taken = 1'b1;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DEST_X:     dest_x = value;
                REG_DEST_Y:     dest_y = value;
                REG_PIC_WIDTH:  pic_width = value;
                REG_PIC_HEIGHT: pic_height = value;
                REG_BLIT_MODE:  blit_mode = value[1:0];
                REG_SCALE_ON:   scale_on = value[0];
                default: ;
            endcase
        endfunction

        function int clamp_origin(logic [CFG_W-1:0] raw);
            int v;
            v = $signed(raw);
            return (v < 0) ? 0 : v;
        endfunction

        function int clamp_side(logic [CFG_W-1:0] raw);
            int v;
            v = raw;
            return (v > MAX_PIC_SIDE) ? MAX_PIC_SIDE : v;
        endfunction

        function void note_item(logic item_mode, logic [PIX_W-1:0] px, logic first,
                                logic [PIX_W-1:0] tidx, logic [PIX_W-1:0] tval);
            int        pw, ph, x0, y0, w, h, dr, dc;
            bit        emit, col_hit;
            fb_write_t wr;
            if (item_mode == ITEM_TABLE_LOAD)
            begin
                xlate[tidx] = tval;
                return;
            end
            if (first)
                rewind_stream();
            pw = clamp_side(pic_width);
            ph = clamp_side(pic_height);
            if (pw == 0 || ph == 0 || in_row >= ph)
                return;
            x0 = clamp_origin(dest_x);
            y0 = clamp_origin(dest_y);
            if (scale_on)
            begin
                w = pw * SCALED_W / FULL_W;
                h = ph * SCALED_H / FULL_H;
                if (x0 + w > FB_WIDTH)
                    w = FB_WIDTH - x0;
                if (y0 + h > FB_HEIGHT)
                    h = FB_HEIGHT - y0;
                row_taken = ((row_phase >> FRAC_W) == in_row) && (out_row < h);
                col_hit = ((col_phase >> FRAC_W) == in_col) && (out_col < w);
                emit = row_taken && col_hit;
                dr = out_row;
                dc = out_col;
                if (col_hit)
                begin
                    out_col++;
                    col_phase += STEP_X;
                end
            end
            else
            begin
                w = pw;
                h = ph;
                if (x0 + w > FB_WIDTH)
                    w = FB_WIDTH - x0;
                if (y0 + h > FB_HEIGHT)
                    h = FB_HEIGHT - y0;
                emit = (in_row < h) && (in_col < w);
                dr = in_row;
                dc = in_col;
            end
            if (blit_mode != BLIT_OPAQUE && px == TRANSPARENT_INDEX)
                emit = 1'b0;
            in_col++;
            if (in_col >= pw)
            begin
                if (scale_on && row_taken)
                begin
                    out_row++;
                    row_phase += STEP_Y;
                end
                in_col = 0;
                out_col = 0;
                col_phase = 0;
                in_row++;
            end
            if (emit)
            begin
                wr.fb_address = ADDR_W'((y0 + dr) * FB_WIDTH + x0 + dc);
                wr.pixel_out = (blit_mode >= BLIT_XLATE) ? xlate[px] : px;
                pending_writes.push_back(wr);
            end
        endfunction

        function void check_write(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
            fb_write_t want;
            if (pending_writes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected write, expected none, got address %0d pixel %0d",
                         $time, addr, pix);
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (addr !== want.fb_address)
            begin
                errors++;
                $display("%0t: fb_address mismatch, expected %0d, got %0d",
                         $time, want.fb_address, addr);
            end
            if (pix !== want.pixel_out)
            begin
                errors++;
                $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                         $time, want.pixel_out, pix);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [PIX_W-1:0]     pixel_value;
    logic                 first_pixel;
    logic [PIX_W-1:0]     table_index;
    logic [PIX_W-1:0]     table_value;
    logic                 out_valid;
    logic                 out_stall;
    logic [ADDR_W-1:0]    fb_address;
    logic [PIX_W-1:0]     pixel_out;

    fb_write_checker book = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int item_count = 0;
    int pixel_items = 0;
    int load_items = 0;
    int settings_count = 0;
    bit table_written [TABLE_DEPTH];
    int written_list[$];

    scaled_transparent_translated_blit_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .pixel_value (pixel_value),
        .first_pixel (first_pixel),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fb_address  (fb_address),
        .pixel_out   (pixel_out)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_write(fb_address, pixel_out);
    end

    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(logic item_mode, logic [PIX_W-1:0] px, logic first,
                             logic [PIX_W-1:0] tidx, logic [PIX_W-1:0] tval);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= item_mode;
        pixel_value <= px;
        first_pixel <= first;
        table_index <= tidx;
        table_value <= tval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_item(item_mode, px, first, tidx, tval);
        item_count++;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px, logic first);
        send_item(ITEM_PIXEL, px, first, PIX_W'($urandom), PIX_W'($urandom));
        pixel_items++;
    endtask

    task automatic send_load(logic [PIX_W-1:0] idx, logic [PIX_W-1:0] val);
        send_item(ITEM_TABLE_LOAD, PIX_W'($urandom), 1'($urandom), idx, val);
        if (!table_written[idx])
            written_list.push_back(idx);
        table_written[idx] = 1'b1;
        load_items++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        book.set_register(idx, CFG_W'(value));
    endtask

    task automatic configure(int dx, int dy, int pw, int ph, int bm, int sc);
        write_register(REG_DEST_X, dx);
        write_register(REG_DEST_Y, dy);
        write_register(REG_PIC_WIDTH, pw);
        write_register(REG_PIC_HEIGHT, ph);
        write_register(REG_BLIT_MODE, bm);
        write_register(REG_SCALE_ON, sc);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Translated pictures only use table entries that have been loaded.
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] v;
        v = PIX_W'($urandom_range(255));
        if (book.blit_mode != BLIT_OPAQUE && $urandom_range(4) == 0)
            v = PIX_W'(TRANSPARENT_INDEX);
        if (book.blit_mode >= BLIT_XLATE && !table_written[v])
            v = PIX_W'(written_list[$urandom_range(written_list.size() - 1)]);
        return v;
    endfunction

    function automatic int pick_origin(int limit);
        case ($urandom_range(5))
            0: return -int'($urandom_range(1, 1024));
            1: return $urandom_range(1) ? -1024 : 1023;
            2: return $urandom_range(limit - 12, limit + 4);
            3: return 0;
            default: return $urandom_range(0, limit - 1);
        endcase
    endfunction

    function automatic int pick_side();
        return ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    function automatic int pick_big();
        case ($urandom_range(2))
            0: return MAX_PIC_SIDE;
            1: return MAX_PIC_SIDE - 1;
            default: return (1 << CFG_W) - 1;
        endcase
    endfunction

    task automatic random_phase(int phase_no);
        int dx, dy, pw, ph, bm, sc, pics, npix, wide, tall;
        case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        dx = pick_origin(FB_WIDTH);
        dy = pick_origin(FB_HEIGHT);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(2))
                0: begin pw = pick_big(); ph = $urandom_range(1, 2); end
                1: begin pw = $urandom_range(2, 3); ph = pick_big(); end
                default: begin pw = pick_big(); ph = pick_big(); end
            endcase
        end
        else
        begin
            pw = pick_side();
            ph = pick_side();
        end
        bm = $urandom_range(3);
        sc = $urandom_range(1);
        settle();
        configure(dx, dy, pw, ph, bm, sc);
        wide = (pw > MAX_PIC_SIDE) ? MAX_PIC_SIDE : pw;
        tall = (ph > MAX_PIC_SIDE) ? MAX_PIC_SIDE : ph;
        pics = $urandom_range(1, 3);
        for (int p = 0; p < pics; p++)
        begin
            npix = wide * tall;
            if (npix == 0)
                npix = 3;
            if (npix > BIG_PICTURE_ITEMS)
                npix = BIG_PICTURE_ITEMS;
            else if ($urandom_range(7) == 0)
                npix = $urandom_range(1, npix);
            npix += $urandom_range(0, 2);
            for (int k = 0; k < npix && item_count < TOTAL_ITEMS; k++)
            begin
                if ($urandom_range(15) == 0)
                    send_load(PIX_W'($urandom), PIX_W'($urandom));
                send_pixel(pick_pixel(), k == 0 && !(p == 0 && $urandom_range(4) == 0));
            end
        end
    endtask

    initial
    begin
        int phase_no;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEST_X;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = ITEM_PIXEL;
        pixel_value = '0;
        first_pixel = 1'b0;
        table_index = '0;
        table_value = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With no first-pixel mark the stream begins at the top-left pixel.
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_load(8'hFF, 8'h00);
        send_load(8'h00, 8'hFF);
        send_load(8'hA5, 8'h5A);
        send_load(8'h5A, 8'hA5);
        send_load(8'h01, 8'h80);

        settle();
        configure(-1024, -1, 3, 2, BLIT_KEYED, 0);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);

        settle();
        configure(255, 191, 2, 1, BLIT_UNUSED, 0);
        send_pixel(8'hA5, 1'b1);
        send_pixel(8'h5A, 1'b0);
        send_load(8'hA5, 8'h33);
        send_pixel(8'hA5, 1'b1);

        settle();
        configure(256, 0, 1, 1, BLIT_OPAQUE, 0);
        send_pixel(8'h7F, 1'b1);
        settle();
        configure(0, 0, 0, 4, BLIT_OPAQUE, 0);
        send_pixel(8'h11, 1'b1);

        settle();
        configure(10, 20, 4, 2, BLIT_OPAQUE, 0);
        send_pixel(8'h40, 1'b1);
        send_pixel(8'h41, 1'b0);
        settle();
        configure(100, 20, 4, 2, BLIT_XLATE, 0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h01, 1'b0);

        settle();
        configure(0, 0, 3, 3, BLIT_OPAQUE, 1);
        for (int k = 0; k < 9; k++)
            send_pixel(PIX_W'($urandom), k == 0);

        // A long output stall backs the block up while items keep coming.
        settle();
        configure(0, 0, 16, 8, BLIT_OPAQUE, 0);
        hold_request = 1'b1;
        for (int k = 0; k < 64; k++)
            send_pixel(PIX_W'($urandom), k == 0);
        settle();
        for (int k = 0; k < 64; k++)
            send_pixel(PIX_W'($urandom), 1'b0);

        phase_no = 0;
        while (item_count < TOTAL_ITEMS)
        begin
            random_phase(phase_no);
            phase_no++;
        end

        settle();
        $display("Run covered %0d pixel items and %0d table loads over %0d register settings,",
                 pixel_items, load_items, settings_count);
        $display("with %0d framebuffer writes compared field by field.", book.writes_checked);
        if (book.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/scaled_transparent_translated_blit_unit.sv
rtl/stb_checker.sv
test/testbench.sv
